// ===== hw/rtl/liu_pkg.sv =====
package liu_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic REG_STEP = 1'b0;
  localparam logic REG_INV  = 1'b1;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } liu_cmd_t;

  typedef struct packed {
    logic pos_lt_step;
    logic last_out;
    logic pipe_en;
  } liu_sts_t;

endpackage

// ===== hw/rtl/linear_interp_upsampler.sv =====
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_sample
// out_      output     out_valid/out_stall out_sample, out_last
// cfg_      input      cfg_we              cfg_index, cfg_wdata
//
// An input sample yields n outputs (n = 0..64). Outputs leave at one per cycle,
// when the output side does not stall, from a three-stage multiply pipeline.
// Synchronous active-low reset: step and inverse to 1.0, phase and history to zero.
// An output stall while out_valid is high freezes the whole pipeline and the burst issue with it.
module linear_interp_upsampler #(
  parameter int SAMPLE_BITS = liu_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = liu_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [FRAC_BITS+6:0]          cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last
);
  import liu_pkg::*;

  liu_cmd_t cmd;
  liu_sts_t sts;

  liu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  liu_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (in_sample),
    .cmd        (cmd),
    .sts        (sts),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_sample (out_sample),
    .out_last   (out_last)
  );

endmodule

// ===== hw/rtl/liu_ctrl.sv =====
module liu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  liu_pkg::liu_sts_t sts,
  output liu_pkg::liu_cmd_t cmd
);
  import liu_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_t;

  state_t state_r;
  logic   in_stall_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
      end
      ST_BURST: begin
        if (!sts.pos_lt_step) begin
          cmd.finish = 1'b1;
        end else if (sts.pipe_en) begin
          cmd.issue  = 1'b1;
          cmd.finish = sts.last_out;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r    <= ST_BURST;
            in_stall_r <= 1'b1;
          end
        end
        ST_BURST: begin
          if (cmd.finish) begin
            state_r    <= ST_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_stall_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_stall = in_stall_r;

endmodule

// ===== hw/rtl/liu_datapath.sv =====
module liu_datapath #(
  parameter int SAMPLE_BITS = liu_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = liu_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [FRAC_BITS+6:0]          cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  liu_pkg::liu_cmd_t             cmd,
  output liu_pkg::liu_sts_t             sts,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last
);
  import liu_pkg::*;

  localparam int POS_W  = FRAC_BITS + 7;
  localparam int INV_W  = FRAC_BITS + 1;
  localparam int PROD_W = POS_W + INV_W;
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int MUL_W  = DIFF_W + FRAC_BITS + 1;
  localparam int SUM_W  = SAMPLE_BITS + 2;

  localparam logic [POS_W-1:0] ONE_Q    = POS_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0] MAX_STEP = POS_W'(64) << FRAC_BITS;
  localparam logic [INV_W-1:0] INV_ONE  = INV_W'(1) << FRAC_BITS;

  // configuration
  logic [POS_W-1:0] step_r;
  logic [INV_W-1:0] inv_r;

  // item state
  logic signed [SAMPLE_BITS-1:0] prev_r;
  logic signed [SAMPLE_BITS-1:0] cur_r;
  logic signed [DIFF_W-1:0]      diff_r;
  logic [FRAC_BITS-1:0]          phase_r;
  logic [POS_W-1:0]              pos_r;

  // pipeline
  logic                          pipe_en;
  logic                          s1_vld_r, s2_vld_r, out_vld_r;
  logic [PROD_W-1:0]             s1_prod_r;
  logic signed [DIFF_W-1:0]      s1_diff_r;
  logic signed [SAMPLE_BITS-1:0] s1_prev_r, s2_prev_r;
  logic                          s1_last_r, s2_last_r, out_last_r;
  logic signed [MUL_W-1:0]       s2_mul_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;

  logic [POS_W-1:0]              step_eff;
  logic [POS_W-1:0]              pos_inc;
  logic [POS_W-1:0]              fin_pos;
  logic [FRAC_BITS-1:0]          w;
  logic signed [FRAC_BITS:0]     w_s;
  logic signed [SUM_W-1:0]       sh;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SAMPLE_BITS-1:0] sat;

  assign step_eff = (step_r > MAX_STEP) ? MAX_STEP : step_r;
  assign pos_inc  = pos_r + ONE_Q;
  assign fin_pos  = cmd.issue ? pos_inc : pos_r;
  assign pipe_en  = !out_vld_r || !out_stall;

  assign sts.pos_lt_step = (pos_r < step_eff);
  assign sts.last_out    = (pos_inc >= step_eff);
  assign sts.pipe_en     = pipe_en;

  // weight saturates at 1.0 - 1 lsb
  assign w   = (|s1_prod_r[PROD_W-1:2*FRAC_BITS]) ? {FRAC_BITS{1'b1}}
                                                  : s1_prod_r[2*FRAC_BITS-1:FRAC_BITS];
  assign w_s = {1'b0, w};

  assign sh  = SUM_W'(s2_mul_r >>> FRAC_BITS);
  assign sum = sh + SUM_W'(s2_prev_r);

  always_comb begin
    if (sum[SUM_W-1:SAMPLE_BITS-1] == {(SUM_W-SAMPLE_BITS+1){1'b0}} ||
        sum[SUM_W-1:SAMPLE_BITS-1] == {(SUM_W-SAMPLE_BITS+1){1'b1}}) begin
      sat = sum[SAMPLE_BITS-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ONE_Q;
      inv_r  <= INV_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP: step_r <= cfg_wdata;
        REG_INV:  inv_r  <= cfg_wdata[INV_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      phase_r <= '0;
    end else if (cmd.finish) begin
      prev_r  <= cur_r;
      phase_r <= fin_pos[FRAC_BITS-1:0] - step_eff[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r  <= in_sample;
      diff_r <= DIFF_W'(in_sample) - DIFF_W'(prev_r);
      pos_r  <= POS_W'(phase_r);
    end else if (cmd.issue) begin
      pos_r  <= pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s1_vld_r  <= cmd.issue;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_prod_r    <= PROD_W'(pos_r) * PROD_W'(inv_r);
      s1_diff_r    <= diff_r;
      s1_prev_r    <= prev_r;
      s1_last_r    <= sts.last_out;
      s2_mul_r     <= MUL_W'(s1_diff_r) * MUL_W'(w_s);
      s2_prev_r    <= s1_prev_r;
      s2_last_r    <= s1_last_r;
      out_sample_r <= sat;
      out_last_r   <= s2_last_r;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

endmodule

// ===== hw/rtl/liu_checker.sv =====
module liu_sva_checker #(
  parameter int SAMPLE_BITS = liu_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] out_sample,
  input logic                   out_last
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while a burst is open");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_last))
    else $error("stalled output changed");

  a_no_out_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("output appeared right after reset");

endmodule

bind linear_interp_upsampler liu_sva_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_liu_sva_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_sample (out_sample),
  .out_last   (out_last)
);

// ===== dv/liu_checker.sv =====
module liu_checker (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic                                     cfg_index,
  input  logic [liu_pkg::FRAC_BITS_DEF+6:0]        cfg_wdata,
  input  logic                                     in_valid,
  input  logic                                     in_stall,
  input  logic signed [liu_pkg::SAMPLE_BITS_DEF-1:0] in_sample,
  input  logic                                     out_valid,
  input  logic                                     out_stall,
  input  logic signed [liu_pkg::SAMPLE_BITS_DEF-1:0] out_sample,
  input  logic                                     out_last,
  output int                                       errors,
  output int                                       pending,
  output int                                       checked
);
  import liu_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam longint unsigned ONE_Q    = 64'd1 << FB;
  localparam longint unsigned MAX_STEP = 64'd64 << FB;
  localparam longint unsigned W_MAX    = ONE_Q - 1;
  localparam longint SMP_MAX = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint SMP_MIN = -SMP_MAX - 1;
  localparam int MAX_BURST = 64;

  typedef struct packed {
    logic signed [SB-1:0] smp;
    logic                 last;
  } interp_out_t;

  interp_out_t          interp_q[$];
  logic signed [SB-1:0] prev_smp;
  logic [FB-1:0]        phase_acc;
  logic [FB+6:0]        step_reg;
  logic [FB:0]          inv_reg;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic predict_burst(input logic signed [SB-1:0] cur);
    longint unsigned step;
    longint unsigned pos;
    longint unsigned w;
    longint          diff;
    longint          y;
    int              n;
    interp_out_t     e;
    step = (step_reg > MAX_STEP) ? MAX_STEP : longint'(step_reg);
    pos  = phase_acc;
    diff = longint'(cur) - longint'(prev_smp);
    n    = 0;
    while (pos < step && n < MAX_BURST) begin
      w = (pos * inv_reg) >> FB;
      if (w > W_MAX) w = W_MAX;
      y = longint'(prev_smp) + ((diff * longint'(w)) >>> FB);
      if (y > SMP_MAX) y = SMP_MAX;
      if (y < SMP_MIN) y = SMP_MIN;
      e.smp  = y[SB-1:0];
      e.last = 1'b0;
      interp_q.push_back(e);
      n++;
      pos += ONE_Q;
    end
    if (n > 0) begin
      e = interp_q.pop_back();
      e.last = 1'b1;
      interp_q.push_back(e);
    end
    phase_acc = FB'(pos - step);
    prev_smp  = cur;
  endtask

  always @(posedge clk) begin
    interp_out_t e;
    if (!rst_n) begin
      prev_smp  = '0;
      phase_acc = '0;
      step_reg  = 23'(ONE_Q);
      inv_reg   = 17'(ONE_Q);
      interp_q.delete();
      errors    = 0;
      checked   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP: step_reg = cfg_wdata;
          REG_INV:  inv_reg  = cfg_wdata[FB:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (interp_q.size() == 0) begin
          report($sformatf("unexpected output sample %0d last %0b", out_sample, out_last));
        end else begin
          e = interp_q.pop_front();
          if (out_sample !== e.smp)
            report($sformatf("out_sample %0d, want %0d", out_sample, e.smp));
          if (out_last !== e.last)
            report($sformatf("out_last %0b, want %0b (sample %0d)", out_last, e.last, e.smp));
          checked++;
        end
      end
      if (in_valid && !in_stall) predict_burst(in_sample);
    end
    pending = interp_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import liu_pkg::*;

  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int FB          = FRAC_BITS_DEF;
  localparam int WDOG_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_PHASES = 12;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic                 cfg_index = REG_STEP;
  logic [FB+6:0]        cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic signed [SB-1:0] in_sample = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic signed [SB-1:0] out_sample;
  logic                 out_last;

  int errors;
  int pending;
  int checked;
  int sent        = 0;
  int settings    = 0;
  int idle_cycles = 0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;
  logic signed [SB-1:0] walk = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  linear_interp_upsampler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .out_last   (out_last)
  );

  liu_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .out_last   (out_last),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  task automatic apply_ratio(input logic [FB+6:0] step, input logic [FB+6:0] inv);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_index <= REG_INV;
    cfg_wdata <= inv;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  task automatic drive_sample(input logic signed [SB-1:0] v);
    in_valid  <= 1'b1;
    in_sample <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [SB-1:0] next_sample();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      walk = SB'($urandom);
    end else if (sel < 6) begin
      case ($urandom_range(0, 4))
        0: walk = 16'sh7FFF;
        1: walk = 16'sh8000;
        2: walk = '0;
        3: walk = -16'sd1;
        default: walk = 16'sd1;
      endcase
    end else begin
      walk = SB'(int'(walk) + $urandom_range(0, 4095) - 2048);
    end
    return walk;
  endfunction

  task automatic send_run(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) drive_sample(next_sample());
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    int len;
    int pct;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(10, 150);
        pct  = (mode == 0) ? 0 : (mode == 1) ? 25 : (mode == 2) ? 50 : 90;
        for (int k = 0; k < len && !(hold_req && !hold_done); k++) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    longint unsigned step;
    longint unsigned inv;
    int count;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset ratio 1.0, full-scale swings
    drive_sample(16'sh7FFF);  drive_sample(16'sh8000); drive_sample(16'sh7FFF);
    drive_sample('0);         drive_sample(-16'sd1);   drive_sample(16'sh8000);
    drain();
    // ratio 64.0 with its matching inverse
    apply_ratio(23'(64 << FB), 23'd1024);
    drive_sample(16'sh7FFF);  drive_sample(16'sh8000); drive_sample(16'sd5);
    drain();
    // ratio above 64.0 is capped; oversized inverse saturates the weight
    apply_ratio(23'h7FFFFF, 23'h1FFFF);
    drive_sample(16'sh8000);  drive_sample(16'sh7FFF);
    drain();
    // zero ratio: no outputs at all
    apply_ratio('0, 23'd1024);
    drive_sample(16'sd100);   drive_sample(-16'sd100);
    drain();
    // zero inverse: every output holds the previous sample
    apply_ratio(23'(2 << FB), '0);
    drive_sample(16'sd12345); drive_sample(-16'sd12345);
    drain();
    // ratio 0.5 with mismatched inverse
    apply_ratio(23'd32768, 23'd65536);
    drive_sample(16'sd1000);  drive_sample(-16'sd1000);
    drive_sample(16'sh7FFF);  drive_sample(16'sh8000);
    drain();
    // ratio 1.5, fractional phase carry
    apply_ratio(23'd98304, 23'd43690);
    drive_sample('0);         drive_sample(16'sd20000); drive_sample(-16'sd20000);
    drive_sample(16'sh7FFF);  drive_sample(16'sh8000);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: step = $urandom_range(1 << FB, 8 << FB);
        6:                step = $urandom_range(8 << FB, 64 << FB);
        7:                step = $urandom_range(0, (1 << FB) - 1);
        8:                step = $urandom_range(0, 23'h7FFFFF);
        default:          step = 64 << FB;
      endcase
      if (ph == 1) step = 4 << FB;
      if (step >= (1 << FB)) inv = (64'd1 << (2 * FB)) / step;
      else inv = $urandom_range(0, 17'h1FFFF);
      if (ph != 1 && $urandom_range(0, 4) == 0) inv = $urandom;
      apply_ratio(23'(step), 23'(inv));
      count = (step > (16 << FB)) ? 6 : 40;
      if (ph == 1) begin
        hold_req = 1'b1;
        count    = 60;
      end
      send_run(count);
      drain();
    end

    $display("Sent %0d samples under %0d ratio settings; checked %0d outputs",
             sent, settings, checked);
    $display("Covered zero, sub-unity and capped ratios, odd inverses, a %0d-cycle output hold",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
